/* hdl/fiber_orientation_color_core_macros.svh */
// Assertion macros shared by the checker of the fiber orientation color core.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef FIBER_ORIENTATION_COLOR_CORE_MACROS_SVH
`define FIBER_ORIENTATION_COLOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FOC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/foc_pkg.sv */
// Package of the fiber orientation color core: default widths, codes and the
// command and status types between controller and datapath. Depends on nothing.
package foc_pkg;

    localparam int FOC_COORD_BITS     = 24;
    localparam int FOC_UNIT_FRAC_BITS = 16;
    localparam int FOC_ID_BITS        = 24;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [1:0] PHASE_NONE   = 2'd0;
    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_MIDDLE = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       hold_direct;
        logic       sq_step;
        logic       acc_step;
        logic [1:0] sq_sel;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       emit_first;
        logic       emit_second;
        logic       use_sum;
        logic       last;
        logic       commit;
    } foc_cmd_t;

    typedef struct packed {
        logic out_free;
    } foc_status_t;

endpackage

/* hdl/foc_ctrl.sv */
// Controller of the fiber orientation color core: sequences squaring, square
// root, division and result transfers. Depends on foc_pkg.
module foc_ctrl
    import foc_pkg::*;
#(
    parameter int COORD_BITS     = FOC_COORD_BITS,
    parameter int UNIT_FRAC_BITS = FOC_UNIT_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        fiber_end,
    input  foc_status_t status,
    output foc_cmd_t    cmd
);

    localparam int ROOT_W    = COORD_BITS + 1;
    localparam int DIV_STEPS = UNIT_FRAC_BITS + 1;
    localparam int MAX_STEPS = (ROOT_W > DIV_STEPS) ? ROOT_W : DIV_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ    = 3'd1;
    localparam logic [2:0] S_SQRT  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT1 = 3'd4;
    localparam logic [2:0] S_EMIT2 = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       phase_reg, phase_next;
    logic             last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= PHASE_NONE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.sq_sel = cnt_reg[1:0];
        cmd.last   = last_reg;
        cmd.use_sum = (phase_reg == PHASE_MIDDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (phase_reg == PHASE_FIRST || phase_reg == PHASE_MIDDLE)
                    begin
                        cmd.capture = 1'b1;
                        last_next   = fiber_end;
                        cnt_next    = '0;
                        state_next  = S_SQ;
                    end
                    else
                    begin
                        cmd.hold_direct = 1'b1;
                        phase_next = fiber_end ? PHASE_NONE : PHASE_FIRST;
                    end
                end
            end
            S_SQ:
            begin
                cmd.sq_step  = (cnt_reg < CNT_W'(3));
                cmd.acc_step = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_init = (cnt_reg == '0);
                cmd.sqrt_step = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(ROOT_W))
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_init = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(DIV_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMIT1:
            begin
                if (status.out_free)
                begin
                    cmd.emit_first = 1'b1;
                    if (last_reg)
                    begin
                        state_next = S_EMIT2;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        phase_next = PHASE_MIDDLE;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT2:
            begin
                if (status.out_free)
                begin
                    cmd.emit_second = 1'b1;
                    phase_next = PHASE_NONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/foc_datapath.sv */
// Datapath of the fiber orientation color core: held point, squarer, iterative
// square root, three division lanes and the output register. Depends on foc_pkg.
module foc_datapath
    import foc_pkg::*;
#(
    parameter int COORD_BITS     = FOC_COORD_BITS,
    parameter int UNIT_FRAC_BITS = FOC_UNIT_FRAC_BITS,
    parameter int ID_BITS        = FOC_ID_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  foc_cmd_t                     cmd,
    output foc_status_t                  status,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic        [ID_BITS-1:0]    point_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic        [ID_BITS-1:0]    color_id,
    output logic        [7:0]            red,
    output logic        [7:0]            green,
    output logic        [7:0]            blue,
    output logic        [7:0]            alpha,
    output logic                         fiber_done,
    output logic                         run_end
);

    localparam int C      = COORD_BITS;
    localparam int F      = UNIT_FRAC_BITS;
    localparam int D_W    = C + 1;
    localparam int SUM_W  = 2 * D_W;
    localparam int ROOT_W = D_W;
    localparam int DIV_W  = D_W + F;
    localparam int Q_W    = F + 1;
    localparam int U_W    = F + 2;
    localparam int S_W    = F + 3;
    localparam int P_W    = U_W + 8;

    logic [2:0][C-1:0]   held_reg, pt_reg;
    logic [ID_BITS-1:0]  held_id_reg, id_reg;
    logic [2:0][D_W-1:0] a_reg;
    logic [2:0]          neg_reg;
    logic [SUM_W-1:0]    sq_reg, sum_reg, rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [2:0][DIV_W-1:0] remd_reg;
    logic [DIV_W-1:0]    den_reg;
    logic [2:0][Q_W-1:0] q_reg;
    logic [2:0][U_W-1:0] prev_reg;

    logic                out_valid_reg, out_valid_next;
    logic [ID_BITS-1:0]  color_id_reg;
    logic [2:0][7:0]     rgb_reg;
    logic                fiber_done_reg, run_end_reg;

    logic [2:0][C-1:0]   pt_in;
    logic [2:0][D_W-1:0] diff;
    logic [ROOT_W+2:0]   rem_sh, trial, rem_sub;
    logic                zero_len;
    logic [2:0][U_W-1:0] unit;
    logic [2:0][S_W-1:0] vsum;
    logic [2:0][U_W-1:0] vabs;
    logic [2:0][P_W-1:0] prod;
    logic [2:0][7:0]     col;
    logic                emit;

    assign pt_in = {point_z, point_y, point_x};
    assign zero_len = (root_reg == '0);
    assign emit = cmd.emit_first | cmd.emit_second;
    assign rem_sh  = {rem_reg[ROOT_W:0], rad_reg[SUM_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {pt_in[i][C-1], pt_in[i]} - {held_reg[i][C-1], held_reg[i]};
            if (zero_len)
            begin
                unit[i] = '0;
            end
            else if (neg_reg[i])
            begin
                unit[i] = '0 - {1'b0, q_reg[i]};
            end
            else
            begin
                unit[i] = {1'b0, q_reg[i]};
            end
            vsum[i] = {prev_reg[i][U_W-1], prev_reg[i]} + {unit[i][U_W-1], unit[i]};
            if (cmd.emit_first && cmd.use_sum)
            begin
                vabs[i] = vsum[i][S_W-1] ? U_W'('0 - vsum[i]) : vsum[i][U_W-1:0];
            end
            else
            begin
                vabs[i] = zero_len ? '0 : {1'b0, q_reg[i]};
            end
            prod[i] = {vabs[i], 8'b0} - {8'b0, vabs[i]};
            col[i] = (cmd.emit_first && cmd.use_sum) ? prod[i][F+8 -: 8] : prod[i][F+7 -: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_direct)
        begin
            held_reg    <= pt_in;
            held_id_reg <= point_id;
        end
        else if (cmd.commit)
        begin
            held_reg    <= pt_reg;
            held_id_reg <= id_reg;
        end
        if (cmd.commit)
        begin
            prev_reg <= unit;
        end
        if (cmd.capture)
        begin
            pt_reg  <= pt_in;
            id_reg  <= point_id;
            sum_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= diff[i][D_W-1];
                a_reg[i]   <= diff[i][D_W-1] ? ('0 - diff[i]) : diff[i];
            end
        end
        if (cmd.sq_step)
        begin
            sq_reg <= a_reg[cmd.sq_sel] * a_reg[cmd.sq_sel];
        end
        if (cmd.acc_step)
        begin
            sum_reg <= sum_reg + sq_reg;
        end
        if (cmd.sqrt_init)
        begin
            rad_reg  <= sum_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sub[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            den_reg <= {root_reg, {F{1'b0}}};
            for (int i = 0; i < 3; i++)
            begin
                remd_reg[i] <= {a_reg[i], {F{1'b0}}};
                q_reg[i]    <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            den_reg <= {1'b0, den_reg[DIV_W-1:1]};
            for (int i = 0; i < 3; i++)
            begin
                if (remd_reg[i] >= den_reg)
                begin
                    remd_reg[i] <= remd_reg[i] - den_reg;
                    q_reg[i]    <= {q_reg[i][Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[i] <= {q_reg[i][Q_W-2:0], 1'b0};
                end
            end
        end
        if (emit)
        begin
            color_id_reg   <= cmd.emit_first ? held_id_reg : id_reg;
            rgb_reg        <= col;
            fiber_done_reg <= cmd.emit_second;
            run_end_reg    <= cmd.emit_second | ~cmd.last;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_free = ~out_valid_reg | out_ready;
    assign out_valid  = out_valid_reg;
    assign color_id   = color_id_reg;
    assign red        = rgb_reg[0];
    assign green      = rgb_reg[1];
    assign blue       = rgb_reg[2];
    assign alpha      = ALPHA_OPAQUE;
    assign fiber_done = fiber_done_reg;
    assign run_end    = run_end_reg;

endmodule

/* hdl/fiber_orientation_color_core.sv */
// Fiber orientation color core: one direction color per polyline point of a fiber
// of two or more points. The time from transfer of a point with a held predecessor
// to its first result is set by the bit-per-cycle square root and the
// shared-denominator division lanes; no new point is taken until that point's results
// are in the output register, while a first point is only held.
// Reset (rst_n low, asynchronous) empties the output and forgets the fiber.
module fiber_orientation_color_core
    import foc_pkg::*;
#(
    parameter int COORD_BITS     = FOC_COORD_BITS,
    parameter int UNIT_FRAC_BITS = FOC_UNIT_FRAC_BITS,
    parameter int ID_BITS        = FOC_ID_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic        [ID_BITS-1:0]    point_id,
    input  logic                         fiber_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic        [ID_BITS-1:0]    color_id,
    output logic        [7:0]            red,
    output logic        [7:0]            green,
    output logic        [7:0]            blue,
    output logic        [7:0]            alpha,
    output logic                         fiber_done,
    output logic                         run_end
);

    foc_cmd_t    cmd;
    foc_status_t status;

    foc_ctrl #(
        .COORD_BITS     (COORD_BITS),
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fiber_end (fiber_end),
        .status    (status),
        .cmd       (cmd)
    );

    foc_datapath #(
        .COORD_BITS     (COORD_BITS),
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS),
        .ID_BITS        (ID_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .point_id   (point_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .color_id   (color_id),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .fiber_done (fiber_done),
        .run_end    (run_end)
    );

endmodule

/* hdl/foc_checker.sv */
// Port-level checker of the fiber orientation color core and its bind.
// Depends on foc_pkg and fiber_orientation_color_core_macros.svh.
`include "fiber_orientation_color_core_macros.svh"

module foc_checker
    import foc_pkg::*;
#(
    parameter int ID_BITS = FOC_ID_BITS
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ID_BITS-1:0] color_id,
    input logic [7:0]         alpha,
    input logic               fiber_done,
    input logic               run_end
);

    `FOC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(color_id), "Stalled result changed.")
    `FOC_ASSERT_NOW(a_alpha, out_valid, alpha == ALPHA_OPAQUE, "Alpha is not opaque.")
    `FOC_ASSERT_NOW(a_done_ends, out_valid && fiber_done, run_end, "Fiber end color does not end the run.")
    `FOC_ASSERT_NOW(a_pair_busy, out_valid && !run_end, !in_ready, "Input taken before the pair was complete.")

endmodule

bind fiber_orientation_color_core foc_checker #(
    .ID_BITS (ID_BITS)
) u_foc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .color_id   (color_id),
    .alpha      (alpha),
    .fiber_done (fiber_done),
    .run_end    (run_end)
);

/* tb/fiber_orientation_color_core_test.sv */
// Self-checking testbench of the fiber orientation color core: random fibers of
// points go in, direction colors are predicted in a scoreboard class and checked.
// Depends on foc_pkg and the fiber_orientation_color_core RTL.
`timescale 1ns / 100ps

module fiber_orientation_color_core_test;
    import foc_pkg::*;

    localparam int CB = FOC_COORD_BITS;
    localparam int UF = FOC_UNIT_FRAC_BITS;
    localparam int IB = FOC_ID_BITS;
    localparam int LIMIT = 20000;

    typedef struct packed {
        logic [IB-1:0] id;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic [7:0]    a;
        logic          done;
        logic          last;
    } color_t;

    class color_scoreboard;
        logic signed [63:0] hx, hy, hz;
        logic [IB-1:0]      hid;
        logic signed [63:0] pu [3];
        logic [1:0]         phase;
        color_t             pending [$];
        int                 errors;

        function new();
            hx = 0; hy = 0; hz = 0; hid = 0;
            pu[0] = 0; pu[1] = 0; pu[2] = 0;
            phase = PHASE_NONE;
            errors = 0;
        endfunction

        function logic [63:0] root(logic [127:0] v);
            logic [127:0] r;
            logic [127:0] b;
            r = 0;
            b = 128'd1 << 126;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r[63:0];
        endfunction

        function void unit_of(logic signed [63:0] x, logic signed [63:0] y,
                              logic signed [63:0] z, output logic signed [63:0] u [3]);
            logic signed [63:0] d [3];
            logic [63:0]  a [3];
            logic [127:0] s;
            logic [63:0]  len, q;
            d[0] = x - hx; d[1] = y - hy; d[2] = z - hz;
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = d[i] < 0 ? -d[i] : d[i];
                s = s + a[i] * a[i];
            end
            len = root(s);
            for (int i = 0; i < 3; i++)
            begin
                if (len == 0)
                    u[i] = 0;
                else
                begin
                    q = (a[i] << UF) / len;
                    u[i] = d[i] < 0 ? -$signed(q) : $signed(q);
                end
            end
        endfunction

        function color_t shade(logic [IB-1:0] id, logic signed [63:0] v [3], int sh,
                               logic done);
            color_t c;
            logic [63:0] m [3];
            for (int i = 0; i < 3; i++)
                m[i] = ((255 * (v[i] < 0 ? -v[i] : v[i])) >> sh);
            c.id = id; c.r = m[0][7:0]; c.g = m[1][7:0]; c.b = m[2][7:0];
            c.a = ALPHA_OPAQUE; c.done = done; c.last = 0;
            return c;
        endfunction

        function void note_point(logic [CB-1:0] px, logic [CB-1:0] py, logic [CB-1:0] pz,
                                 logic [IB-1:0] id, logic fin);
            logic signed [63:0] x, y, z;
            logic signed [63:0] u [3];
            logic signed [63:0] s [3];
            color_t got [$];
            x = $signed(px); y = $signed(py); z = $signed(pz);
            if (phase == PHASE_FIRST || phase == PHASE_MIDDLE)
            begin
                unit_of(x, y, z, u);
                if (phase == PHASE_FIRST)
                    got.push_back(shade(hid, u, UF, 0));
                else
                begin
                    for (int i = 0; i < 3; i++) s[i] = pu[i] + u[i];
                    got.push_back(shade(hid, s, UF + 1, 0));
                end
                if (fin)
                begin
                    got.push_back(shade(id, u, UF, 1));
                    phase = PHASE_NONE;
                end
                else
                begin
                    for (int i = 0; i < 3; i++) pu[i] = u[i];
                    phase = PHASE_MIDDLE;
                end
            end
            else
                phase = fin ? PHASE_NONE : PHASE_FIRST;
            if (!fin || got.size() == 0)
            begin
                hx = x; hy = y; hz = z; hid = id;
            end
            if (got.size() > 0) got[got.size() - 1].last = 1;
            foreach (got[i]) pending.push_back(got[i]);
        endfunction

        function void check_color(color_t c);
            color_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected color, expected none, actual %h", $time, c);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.id != c.id)
            begin
                $display("%0t: color_id expected %h actual %h", $time, e.id, c.id);
                errors++;
            end
            if (e.r != c.r)
            begin
                $display("%0t: red expected %h actual %h", $time, e.r, c.r);
                errors++;
            end
            if (e.g != c.g)
            begin
                $display("%0t: green expected %h actual %h", $time, e.g, c.g);
                errors++;
            end
            if (e.b != c.b)
            begin
                $display("%0t: blue expected %h actual %h", $time, e.b, c.b);
                errors++;
            end
            if (e.a != c.a)
            begin
                $display("%0t: alpha expected %h actual %h", $time, e.a, c.a);
                errors++;
            end
            if (e.done != c.done)
            begin
                $display("%0t: fiber_done expected %b actual %b", $time, e.done, c.done);
                errors++;
            end
            if (e.last != c.last)
            begin
                $display("%0t: run_end expected %b actual %b", $time, e.last, c.last);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, in_valid, in_ready, out_valid, out_ready, fiber_end;
    logic signed [CB-1:0] point_x, point_y, point_z;
    logic [IB-1:0] point_id, color_id;
    logic [7:0] red, green, blue, alpha;
    logic fiber_done, run_end;

    color_scoreboard sb;
    bit quiet;
    bit hold_off;
    int stuck;

    fiber_orientation_color_core u_dut (.*);

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                              logic [IB-1:0] id, logic fin);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= x; point_y <= y; point_z <= z; point_id <= id; fiber_end <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_point(x, y, z, id, fin);
    endtask

    function automatic logic [CB-1:0] near(logic [CB-1:0] base);
        case ($urandom_range(0, 3))
            0: return base;
            1: return base + CB'($urandom_range(0, 15)) - CB'(8);
            2: return base + CB'($urandom_range(0, 4095)) - CB'(2048);
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic send_fiber(int n);
        logic [CB-1:0] x, y, z;
        x = CB'($urandom); y = CB'($urandom); z = CB'($urandom);
        for (int i = 0; i < n; i++)
        begin
            send_point(x, y, z, IB'($urandom), i == n - 1);
            x = near(x); y = near(y); z = near(z);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_color(color_t'{color_id, red, green, blue, alpha, fiber_done, run_end});
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck > LIMIT)
        begin
            $display("fiber_orientation_color_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [CB-1:0] mx, mn;
        sb = new();
        quiet = 0; hold_off = 0; stuck = 0;
        rst_n = 1'b0; in_valid = 1'b0; fiber_end = 1'b0;
        point_x = 0; point_y = 0; point_z = 0; point_id = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        send_point(1, 2, 3, 24'hFFFFFF, 1);
        send_point(mn, mn, mn, 0, 0);
        send_point(mx, mx, mx, 24'hFFFFFF, 1);
        send_point(mx, mn, 0, 1, 0);
        send_point(mn, mx, mx, 2, 0);
        send_point(mn, mx, mx, 3, 0);
        send_point(0, 0, mn, 4, 1);
        send_point(5, 5, 5, 5, 0);
        send_point(5, 5, 5, 6, 1);
        send_point(0, 0, 0, 7, 0);
        send_point(256, 0, 0, 8, 0);
        send_point(256, -256, 0, 9, 0);
        send_point(256, -256, 256, 10, 0);
        send_point(1, 1, 1, 11, 1);
        hold_off = 1;
        repeat (6) send_fiber(4);
        for (int k = 0; k < 315; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_point(CB'($urandom), CB'($urandom), CB'($urandom), IB'($urandom),
                           1'($urandom));
            else
                send_fiber($urandom_range(1, 8));
            if (k == 265) quiet = 1;
        end
        send_point(0, 0, 0, 0, 1);
        in_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("fiber_orientation_color_core: match");
        else
            $display("fiber_orientation_color_core: mismatch");
        $finish;
    end
endmodule
